FILE: src/keypoint_grid_suppression_filter_top_defines.svh
// Assertion macros for the keypoint grid suppression filter.
// Included by the filter top, the module that carries concurrent assertions; expects clk and rst in scope.
`ifndef KEYPOINT_GRID_SUPPRESSION_FILTER_TOP_DEFINES_SVH
`define KEYPOINT_GRID_SUPPRESSION_FILTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KGS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/kgs_pkg.sv
// Shared types and constants for the keypoint grid suppression filter.
// No dependencies; used by the scaling unit, the filter top and the testbench.
`default_nettype none

package kgs_pkg;

  // Parameter defaults
  localparam int unsigned GRID_COLUMNS_DEF    = 512;
  localparam int unsigned GRID_ROWS_DEF       = 512;
  localparam int unsigned COORD_FRAC_BITS_DEF = 4;

  // Field and register widths
  localparam int unsigned POS_W      = 16;
  localparam int unsigned CINV_W     = 17;
  localparam int unsigned PATCH_W    = 8;
  localparam int unsigned IMG_W      = 13;
  localparam int unsigned MAXF_W     = 16;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned CELL_W     = 9;
  localparam int unsigned VERDICT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned IN_DATA_W  = 2 * POS_W;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_BITS   = ID_W + 2 * CELL_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = 1 + VERDICT_W;

  // Scaling arithmetic: position times Q1.16 reciprocal
  localparam int unsigned INV_FRAC = 16;
  localparam int unsigned PROD_W   = POS_W + CINV_W;
  localparam int unsigned Q_W      = PROD_W - INV_FRAC;
  localparam int unsigned Q1_W     = Q_W + 1;

  // Register reset values
  localparam logic              MIN_DIST_RST  = 1'b0;
  localparam logic [CINV_W-1:0] CELL_INV_RST  = CINV_W'(32768);
  localparam logic [PATCH_W-1:0] PATCH_RST    = '0;
  localparam logic [IMG_W-1:0]  IMG_WIDTH_RST = IMG_W'(640);
  localparam logic [IMG_W-1:0]  IMG_HEIGHT_RST = IMG_W'(480);
  localparam logic [MAXF_W-1:0] MAXF_RST      = '0;
  localparam logic [ID_W-1:0]   ID_BASE_RST   = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DIST   = 3'd0,
    REG_CELL_INV   = 3'd1,
    REG_PATCH_SIZE = 3'd2,
    REG_IMG_WIDTH  = 3'd3,
    REG_IMG_HEIGHT = 3'd4,
    REG_MAX_FEAT   = 3'd5,
    REG_ID_BASE    = 3'd6
  } cfg_reg_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ACCEPT   = 2'd0,
    VERDICT_QUOTA    = 2'd1,
    VERDICT_PATCH    = 2'd2,
    VERDICT_OCCUPIED = 2'd3
  } verdict_t;

  typedef enum logic {
    OP_EXTENT = 1'b0,
    OP_CELL   = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     valid;
    unit_op_t op;
  } unit_req_t;

endpackage

`default_nettype wire

FILE: src/kgs_scale_unit.sv
// Shared scaling unit: multiply by the cell reciprocal, shift, then clamp or saturate.
// Two-stage pipeline; depends on kgs_pkg.
`default_nettype none

module kgs_scale_unit #(
  parameter int unsigned LIM_W     = 10,
  parameter int unsigned FRAC_BITS = kgs_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kgs_pkg::unit_req_t          req,
  input  logic [kgs_pkg::POS_W-1:0]   operand,
  input  logic [kgs_pkg::CINV_W-1:0]  cell_inverse,
  input  logic [LIM_W-1:0]            limit,
  output logic                        res_valid,
  output logic [LIM_W-1:0]            res
);

  localparam int unsigned CELL_SHIFT = kgs_pkg::INV_FRAC + FRAC_BITS;

  logic                          prod_valid;
  kgs_pkg::unit_op_t             prod_op;
  logic [kgs_pkg::PROD_W-1:0]    prod;
  logic [LIM_W-1:0]              prod_limit;
  logic [kgs_pkg::Q_W-1:0]       q;
  logic [kgs_pkg::Q1_W-1:0]      q1;
  logic [kgs_pkg::Q1_W-1:0]      lim_ext;
  logic [LIM_W-1:0]              res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= req.valid;
    end
    prod       <= kgs_pkg::PROD_W'(operand) * kgs_pkg::PROD_W'(cell_inverse);
    prod_op    <= req.op;
    prod_limit <= limit;
  end

  always_comb begin
    if (prod_op == kgs_pkg::OP_CELL) begin
      q = kgs_pkg::Q_W'(prod >> CELL_SHIFT);
    end else begin
      q = kgs_pkg::Q_W'(prod >> kgs_pkg::INV_FRAC);
    end
    q1      = {1'b0, q} + kgs_pkg::Q1_W'(1);
    lim_ext = kgs_pkg::Q1_W'(prod_limit);
    unique case (prod_op)
      kgs_pkg::OP_EXTENT: begin
        // saturate the grid extent at the grid size
        res_next = (q1 > lim_ext) ? prod_limit : LIM_W'(q1);
      end
      kgs_pkg::OP_CELL: begin
        // clamp the cell index to the last cell in use
        res_next = ({1'b0, q} >= lim_ext) ? (prod_limit - LIM_W'(1)) : LIM_W'(q);
      end
      default: res_next = prod_limit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= prod_valid;
    end
    res <= res_next;
  end

endmodule

`default_nettype wire

FILE: src/kgs_occ_mem.sv
// Occupancy grid memory: one row of cell bits per address.
// One write and one registered read per cycle; no dependencies.
`default_nettype none

module kgs_occ_mem #(
  parameter int unsigned ROWS = 512,
  parameter int unsigned COLS = 512
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(ROWS)-1:0]  rd_addr,
  output logic [COLS-1:0]          rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(ROWS)-1:0]  wr_addr,
  input  logic [COLS-1:0]          wr_data
);

  logic [COLS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/keypoint_grid_suppression_filter_top.sv
// Keypoint grid suppression filter: sequencer, registers, border/quota/occupancy checks, output stage.
// Depends on kgs_pkg, kgs_scale_unit, kgs_occ_mem and the assertion macro header.
`default_nettype none
`include "keypoint_grid_suppression_filter_top_defines.svh"

// Keypoints (Q12.4 positions, sorted by falling response) enter one at a time on the s_ side
// and leave as one verdict each on the m_ side. A keypoint passes through the cell steps, the
// check and the result load, plus the marking steps when it is accepted with the grid check
// on; the input is not ready meanwhile. The cell lookup goes through one shared
// multiplier (two pipelined products per keypoint) and marking is a read-modify-write of three
// grid rows through the single read and write port of the occupancy memory. A keypoint flagged
// first of list first runs the grid-size steps and a clearing pass over max(previous rows,
// new rows) rows. After reset a clearing pass over GRID_ROWS rows runs before the first
// keypoint is taken; configuration writes are taken throughout. A finished result waits in the
// output register while the next keypoint is taken and worked on.
module keypoint_grid_suppression_filter_top #(
  parameter int unsigned GRID_COLUMNS    = kgs_pkg::GRID_COLUMNS_DEF,
  parameter int unsigned GRID_ROWS       = kgs_pkg::GRID_ROWS_DEF,
  parameter int unsigned COORD_FRAC_BITS = kgs_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [kgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kgs_pkg::CFG_DATA_W-1:0]   cfg_data,
  // keypoint input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [kgs_pkg::IN_DATA_W-1:0]    s_tdata,   // pos_x, pos_y
  input  logic [kgs_pkg::IN_USER_W-1:0]    s_tuser,   // first_of_list
  // verdict output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [kgs_pkg::OUT_DATA_W-1:0]   m_tdata,   // feature_id, cell_column, cell_row, pad
  output logic [kgs_pkg::OUT_USER_W-1:0]   m_tuser    // accepted, verdict
);

  localparam int unsigned COL_AW = $clog2(GRID_COLUMNS);
  localparam int unsigned ROW_AW = $clog2(GRID_ROWS);
  localparam int unsigned CU_W   = $clog2(GRID_COLUMNS + 1);
  localparam int unsigned RU_W   = $clog2(GRID_ROWS + 1);
  localparam int unsigned CU1_W  = CU_W + 1;
  localparam int unsigned RU1_W  = RU_W + 1;
  localparam int unsigned LIM_W  = (CU_W > RU_W) ? CU_W : RU_W;
  localparam int unsigned BW     = kgs_pkg::POS_W + 1;

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_EXT_W    = 14'b00000000000010,
    ST_EXT_H    = 14'b00000000000100,
    ST_EXT_COLS = 14'b00000000001000,
    ST_EXT_ROWS = 14'b00000000010000,
    ST_CLEAR    = 14'b00000000100000,
    ST_CELL_X   = 14'b00000001000000,
    ST_CELL_Y   = 14'b00000010000000,
    ST_CAP_X    = 14'b00000100000000,
    ST_CAP_Y    = 14'b00001000000000,
    ST_CHECK    = 14'b00010000000000,
    ST_MARK_UP  = 14'b00100000000000,
    ST_MARK_DN  = 14'b01000000000000,
    ST_EMIT     = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic                         min_dist_enable;
  logic [kgs_pkg::CINV_W-1:0]   cell_inverse;
  logic [kgs_pkg::PATCH_W-1:0]  patch_size;
  logic [kgs_pkg::IMG_W-1:0]    image_width;
  logic [kgs_pkg::IMG_W-1:0]    image_height;
  logic [kgs_pkg::MAXF_W-1:0]   max_features;
  logic [kgs_pkg::ID_W-1:0]     id_base;

  // list state
  logic [kgs_pkg::MAXF_W-1:0]   accept_count;
  logic [CU_W-1:0]              cols_used;
  logic [RU_W-1:0]              rows_used;
  logic [RU_W-1:0]              new_rows;
  logic [ROW_AW-1:0]            clear_addr;
  logic [RU_W-1:0]              clear_limit;
  logic                         clear_item;
  logic                         clear_last;

  // current keypoint
  logic [kgs_pkg::POS_W-1:0]    pos_x;
  logic [kgs_pkg::POS_W-1:0]    pos_y;
  logic [COL_AW-1:0]            col;
  logic [ROW_AW-1:0]            row;
  logic                         mark;
  kgs_pkg::verdict_t            verdict;
  kgs_pkg::verdict_t            verdict_next;
  logic [kgs_pkg::ID_W-1:0]     feature_id;

  // shared unit
  kgs_pkg::unit_req_t           unit_req;
  logic [kgs_pkg::POS_W-1:0]    unit_operand;
  logic [LIM_W-1:0]             unit_limit;
  logic                         unit_res_valid;
  logic [LIM_W-1:0]             unit_res;

  // grid memory
  logic                         mem_rd_en;
  logic [ROW_AW-1:0]            mem_rd_addr;
  logic [GRID_COLUMNS-1:0]      mem_rd_data;
  logic                         mem_wr_en;
  logic [ROW_AW-1:0]            mem_wr_addr;
  logic [GRID_COLUMNS-1:0]      mem_wr_data;

  // checks
  logic [BW-1:0]                ip_x;
  logic [BW-1:0]                ip_y;
  logic [BW-1:0]                half;
  logic                         inside_x;
  logic                         inside_y;
  logic                         quota_hit;
  logic                         patch_fail;
  logic                         occupied;
  logic                         has_right;
  logic                         has_up;
  logic                         has_down;
  logic [GRID_COLUMNS-1:0]      col_bit;
  logic [GRID_COLUMNS-1:0]      row_mask;
  logic                         take;
  logic                         emit_load;

  assign s_tready  = (state == ST_IDLE);
  assign take      = s_tvalid && s_tready;
  assign emit_load = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist_enable <= kgs_pkg::MIN_DIST_RST;
      cell_inverse    <= kgs_pkg::CELL_INV_RST;
      patch_size      <= kgs_pkg::PATCH_RST;
      image_width     <= kgs_pkg::IMG_WIDTH_RST;
      image_height    <= kgs_pkg::IMG_HEIGHT_RST;
      max_features    <= kgs_pkg::MAXF_RST;
      id_base         <= kgs_pkg::ID_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kgs_pkg::REG_MIN_DIST:   min_dist_enable <= cfg_data[0];
        kgs_pkg::REG_CELL_INV:   cell_inverse    <= cfg_data[kgs_pkg::CINV_W-1:0];
        kgs_pkg::REG_PATCH_SIZE: patch_size      <= cfg_data[kgs_pkg::PATCH_W-1:0];
        kgs_pkg::REG_IMG_WIDTH:  image_width     <= cfg_data[kgs_pkg::IMG_W-1:0];
        kgs_pkg::REG_IMG_HEIGHT: image_height    <= cfg_data[kgs_pkg::IMG_W-1:0];
        kgs_pkg::REG_MAX_FEAT:   max_features    <= cfg_data[kgs_pkg::MAXF_W-1:0];
        kgs_pkg::REG_ID_BASE:    id_base         <= cfg_data[kgs_pkg::ID_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- shared unit
  always_comb begin
    unit_req.valid = 1'b0;
    unit_req.op    = kgs_pkg::OP_CELL;
    unit_operand   = pos_x;
    unit_limit     = LIM_W'(cols_used);
    unique case (state)
      ST_EXT_W: begin
        unit_req.valid = 1'b1;
        unit_req.op    = kgs_pkg::OP_EXTENT;
        unit_operand   = kgs_pkg::POS_W'(image_width);
        unit_limit     = LIM_W'(GRID_COLUMNS);
      end
      ST_EXT_H: begin
        unit_req.valid = 1'b1;
        unit_req.op    = kgs_pkg::OP_EXTENT;
        unit_operand   = kgs_pkg::POS_W'(image_height);
        unit_limit     = LIM_W'(GRID_ROWS);
      end
      ST_CELL_X: begin
        unit_req.valid = 1'b1;
      end
      ST_CELL_Y: begin
        unit_req.valid = 1'b1;
        unit_operand   = pos_y;
        unit_limit     = LIM_W'(rows_used);
      end
      default: ;
    endcase
  end

  kgs_scale_unit #(
    .LIM_W     (LIM_W),
    .FRAC_BITS (COORD_FRAC_BITS)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .req          (unit_req),
    .operand      (unit_operand),
    .cell_inverse (cell_inverse),
    .limit        (unit_limit),
    .res_valid    (unit_res_valid),
    .res          (unit_res)
  );

  // ---------------------------------------------------------------- checks
  always_comb begin
    ip_x     = BW'(pos_x >> COORD_FRAC_BITS);
    ip_y     = BW'(pos_y >> COORD_FRAC_BITS);
    half     = BW'(patch_size >> 1);
    inside_x = (ip_x > half) && ((ip_x + half) < BW'(image_width));
    inside_y = (ip_y > half) && ((ip_y + half) < BW'(image_height));

    quota_hit  = (max_features != '0) && (accept_count >= max_features);
    patch_fail = (patch_size != '0) && !(inside_x && inside_y);
    occupied   = min_dist_enable && mem_rd_data[col];

    priority if (quota_hit) begin
      verdict_next = kgs_pkg::VERDICT_QUOTA;
    end else if (patch_fail) begin
      verdict_next = kgs_pkg::VERDICT_PATCH;
    end else if (occupied) begin
      verdict_next = kgs_pkg::VERDICT_OCCUPIED;
    end else begin
      verdict_next = kgs_pkg::VERDICT_ACCEPT;
    end

    has_right = (CU1_W'(col) + CU1_W'(1)) < CU1_W'(cols_used);
    has_up    = (row != '0);
    has_down  = (RU1_W'(row) + RU1_W'(1)) < RU1_W'(rows_used);
    col_bit   = {{(GRID_COLUMNS-1){1'b0}}, 1'b1} << col;
    row_mask  = col_bit | (col_bit >> 1) | (has_right ? (col_bit << 1) : '0);

    new_rows   = min_dist_enable ? RU_W'(unit_res) : RU_W'(1);
    clear_last = (RU1_W'(clear_addr) + RU1_W'(1)) >= RU1_W'(clear_limit);
  end

  // ---------------------------------------------------------------- grid memory access
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = row;
    mem_wr_en   = 1'b0;
    mem_wr_addr = row;
    mem_wr_data = mem_rd_data | row_mask;
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clear_addr;
        mem_wr_data = '0;
      end
      ST_CAP_Y: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = ROW_AW'(unit_res);
      end
      ST_CHECK: begin
        // mark own row, fetch the row above
        mem_wr_en   = min_dist_enable && (verdict_next == kgs_pkg::VERDICT_ACCEPT);
        mem_rd_en   = has_up;
        mem_rd_addr = row - ROW_AW'(1);
      end
      ST_MARK_UP: begin
        mem_wr_en   = mark && has_up;
        mem_wr_addr = row - ROW_AW'(1);
        mem_wr_data = mem_rd_data | col_bit;
        mem_rd_en   = has_down;
        mem_rd_addr = row + ROW_AW'(1);
      end
      ST_MARK_DN: begin
        mem_wr_en   = mark && has_down;
        mem_wr_addr = row + ROW_AW'(1);
        mem_wr_data = mem_rd_data | col_bit;
      end
      default: ;
    endcase
  end

  kgs_occ_mem #(
    .ROWS (GRID_ROWS),
    .COLS (GRID_COLUMNS)
  ) u_occ (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          state_next = s_tuser[0] ? ST_EXT_W : ST_CELL_X;
        end
      end
      ST_EXT_W:    state_next = ST_EXT_H;
      ST_EXT_H:    state_next = ST_EXT_COLS;
      ST_EXT_COLS: state_next = ST_EXT_ROWS;
      ST_EXT_ROWS: state_next = ST_CLEAR;
      ST_CLEAR: begin
        if (clear_last) begin
          state_next = clear_item ? ST_CELL_X : ST_IDLE;
        end
      end
      ST_CELL_X:   state_next = ST_CELL_Y;
      ST_CELL_Y:   state_next = ST_CAP_X;
      ST_CAP_X:    state_next = ST_CAP_Y;
      ST_CAP_Y:    state_next = ST_CHECK;
      ST_CHECK: begin
        if (min_dist_enable && (verdict_next == kgs_pkg::VERDICT_ACCEPT)) begin
          state_next = ST_MARK_UP;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_MARK_UP:  state_next = ST_MARK_DN;
      ST_MARK_DN:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_load) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clear_addr   <= '0;
      clear_limit  <= RU_W'(GRID_ROWS);
      clear_item   <= 1'b0;
      accept_count <= '0;
      cols_used    <= CU_W'(1);
      rows_used    <= RU_W'(1);
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (take && s_tuser[0]) begin
        accept_count <= '0;
      end
      if (state == ST_EXT_COLS) begin
        cols_used <= min_dist_enable ? CU_W'(unit_res) : CU_W'(1);
      end
      if (state == ST_EXT_ROWS) begin
        // sweep every row the last list could have touched or this one will read
        rows_used   <= new_rows;
        clear_limit <= (new_rows > rows_used) ? new_rows : rows_used;
        clear_addr  <= '0;
        clear_item  <= 1'b1;
      end
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + ROW_AW'(1);
      end
      if ((state == ST_CHECK) && (verdict_next == kgs_pkg::VERDICT_ACCEPT)) begin
        accept_count <= accept_count + kgs_pkg::MAXF_W'(1);
      end
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      pos_x <= s_tdata[kgs_pkg::POS_W-1:0];
      pos_y <= s_tdata[2*kgs_pkg::POS_W-1:kgs_pkg::POS_W];
    end
    if (state == ST_CAP_X) begin
      col <= COL_AW'(unit_res);
    end
    if (state == ST_CAP_Y) begin
      row <= ROW_AW'(unit_res);
    end
    if (state == ST_CHECK) begin
      verdict <= verdict_next;
      mark    <= min_dist_enable && (verdict_next == kgs_pkg::VERDICT_ACCEPT);
      if (verdict_next == kgs_pkg::VERDICT_ACCEPT) begin
        feature_id <= id_base + kgs_pkg::ID_W'(accept_count);
      end else begin
        feature_id <= '0;
      end
    end
    if (emit_load) begin
      m_tdata <= kgs_pkg::OUT_DATA_W'({kgs_pkg::CELL_W'(row), kgs_pkg::CELL_W'(col), feature_id});
      m_tuser <= {verdict, (verdict == kgs_pkg::VERDICT_ACCEPT)};
    end
  end

  // ---------------------------------------------------------------- assertions
  `KGS_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready,
                   "keypoint transfer while another keypoint is in flight")
  `KGS_ASSERT_SAME(a_mark_in_grid, mem_wr_en && (state != ST_CLEAR),
                   RU1_W'(mem_wr_addr) < RU1_W'(rows_used), "grid mark outside the rows in use")
  `KGS_ASSERT_SAME(a_unit_result_taken, unit_res_valid,
                   state == ST_EXT_COLS || state == ST_EXT_ROWS ||
                   state == ST_CAP_X || state == ST_CAP_Y,
                   "scaling unit result arrives outside a capture step")
  `KGS_ASSERT_NEXT(a_emit_completes, emit_load, m_tvalid && s_tready,
                   "result load did not present the result and free the input")

endmodule

`default_nettype wire

FILE: tb/keypoint_verdict_checker.sv
`timescale 1ns / 100ps
// Verdict scoreboard for the keypoint grid suppression filter: watches the register port and
// both stream channels, predicts each verdict and compares it. Depends on kgs_pkg only.
module keypoint_verdict_checker
  import kgs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x, pos_y
  input  logic [IN_USER_W-1:0]  s_tuser,   // first_of_list
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // feature_id, cell_column, cell_row, pad
  input  logic [OUT_USER_W-1:0] m_tuser,   // accepted, verdict
  output int                    error_count,
  output int                    pending
);

  localparam int unsigned COLS = GRID_COLUMNS_DEF;
  localparam int unsigned ROWS = GRID_ROWS_DEF;
  localparam int unsigned FRAC = COORD_FRAC_BITS_DEF;

  typedef struct packed {
    logic                accepted;
    verdict_t            verdict;
    logic [ID_W-1:0]     feature_id;
    logic [CELL_W-1:0]   col;
    logic [CELL_W-1:0]   row;
  } kp_result_t;

  logic [COLS-1:0]    occupied [ROWS];
  logic [MAXF_W-1:0]  accepted_so_far;
  int unsigned        cols_in_use;
  int unsigned        rows_in_use;

  logic               grid_check;
  logic [CINV_W-1:0]  cell_recip;
  logic [PATCH_W-1:0] patch_side;
  logic [IMG_W-1:0]   img_w;
  logic [IMG_W-1:0]   img_h;
  logic [MAXF_W-1:0]  quota;
  logic [ID_W-1:0]    id_start;

  kp_result_t awaited_verdicts[$];

  // Grid extent along one axis, latched at the start of a list.
  function automatic int unsigned grid_span(input logic [IMG_W-1:0] pixels,
                                            input int unsigned cap);
    logic [IMG_W+CINV_W-1:0] prod;
    int unsigned n;
    prod = (IMG_W+CINV_W)'(pixels) * (IMG_W+CINV_W)'(cell_recip);
    n = 1 + int'(prod >> INV_FRAC);
    if (!grid_check) return 1;
    return (n > cap) ? cap : n;
  endfunction

  function automatic int unsigned cell_index(input logic [POS_W-1:0] pos,
                                             input int unsigned used);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] c;
    prod = PROD_W'(pos) * PROD_W'(cell_recip);
    c = prod >> (INV_FRAC + FRAC);
    if (c >= PROD_W'(used)) c = PROD_W'(used - 1);
    return int'(c);
  endfunction

  function automatic logic within_border(input logic [POS_W-1:0] pos,
                                         input logic [IMG_W-1:0] limit);
    int ip;
    int half;
    ip = int'(pos >> FRAC);
    half = int'(patch_side >> 1);
    return (ip - half > 0) && (ip + half < int'(limit));
  endfunction

  function automatic kp_result_t judge_keypoint(input logic [POS_W-1:0] px,
                                                input logic [POS_W-1:0] py,
                                                input logic first);
    kp_result_t r;
    int c;
    int rw;
    if (first) begin
      for (int i = 0; i < ROWS; i++) occupied[i] = '0;
      accepted_so_far = '0;
      cols_in_use = grid_span(img_w, COLS);
      rows_in_use = grid_span(img_h, ROWS);
    end
    c = cell_index(px, cols_in_use);
    rw = cell_index(py, rows_in_use);
    r.col = CELL_W'(c);
    r.row = CELL_W'(rw);
    r.feature_id = '0;
    if (quota != '0 && accepted_so_far >= quota) begin
      r.verdict = VERDICT_QUOTA;
    end else if (patch_side != '0 &&
                 !(within_border(px, img_w) && within_border(py, img_h))) begin
      r.verdict = VERDICT_PATCH;
    end else if (grid_check && occupied[rw][c]) begin
      r.verdict = VERDICT_OCCUPIED;
    end else begin
      r.verdict = VERDICT_ACCEPT;
    end
    r.accepted = (r.verdict == VERDICT_ACCEPT);
    if (r.accepted) begin
      // mark the cell and its four neighbours, clipped at the grid edge
      if (grid_check) begin
        occupied[rw][c] = 1'b1;
        if (c > 0) occupied[rw][c-1] = 1'b1;
        if (rw > 0) occupied[rw-1][c] = 1'b1;
        if (c + 1 < int'(cols_in_use)) occupied[rw][c+1] = 1'b1;
        if (rw + 1 < int'(rows_in_use)) occupied[rw+1][c] = 1'b1;
      end
      r.feature_id = id_start + ID_W'(accepted_so_far);
      accepted_so_far = accepted_so_far + 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    kp_result_t want;
    kp_result_t got;
    if (rst) begin
      for (int i = 0; i < ROWS; i++) occupied[i] = '0;
      accepted_so_far = '0;
      cols_in_use = 1;
      rows_in_use = 1;
      grid_check = MIN_DIST_RST;
      cell_recip = CELL_INV_RST;
      patch_side = PATCH_RST;
      img_w = IMG_WIDTH_RST;
      img_h = IMG_HEIGHT_RST;
      quota = MAXF_RST;
      id_start = ID_BASE_RST;
      awaited_verdicts.delete();
      error_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MIN_DIST:   grid_check = cfg_data[0];
          REG_CELL_INV:   cell_recip = cfg_data[CINV_W-1:0];
          REG_PATCH_SIZE: patch_side = cfg_data[PATCH_W-1:0];
          REG_IMG_WIDTH:  img_w = cfg_data[IMG_W-1:0];
          REG_IMG_HEIGHT: img_h = cfg_data[IMG_W-1:0];
          REG_MAX_FEAT:   quota = cfg_data[MAXF_W-1:0];
          REG_ID_BASE:    id_start = cfg_data[ID_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.accepted = m_tuser[0];
        got.verdict = verdict_t'(m_tuser[2:1]);
        got.feature_id = m_tdata[ID_W-1:0];
        got.col = m_tdata[ID_W +: CELL_W];
        got.row = m_tdata[ID_W+CELL_W +: CELL_W];
        if (awaited_verdicts.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected result acc=%0d v=%0d id=%h cell=(%0d,%0d)",
                     $realtime, got.accepted, got.verdict, got.feature_id, got.col, got.row);
        end else begin
          want = awaited_verdicts.pop_front();
          if (got.accepted !== want.accepted || got.verdict !== want.verdict ||
              got.feature_id !== want.feature_id || got.col !== want.col ||
              got.row !== want.row) begin
            error_count++;
            if (error_count <= 10) begin
              $display("%0t: verdict mismatch: want acc=%0d v=%0d id=%h cell=(%0d,%0d)",
                       $realtime, want.accepted, want.verdict, want.feature_id, want.col,
                       want.row);
              $display("%0t: verdict mismatch: got  acc=%0d v=%0d id=%h cell=(%0d,%0d)",
                       $realtime, got.accepted, got.verdict, got.feature_id, got.col, got.row);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        awaited_verdicts.push_back(judge_keypoint(s_tdata[POS_W-1:0],
                                                  s_tdata[2*POS_W-1:POS_W], s_tuser[0]));
    end
    pending = awaited_verdicts.size();
  end

endmodule

FILE: tb/keypoint_grid_suppression_filter_top_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the keypoint grid suppression filter: directed keypoints, then random
// lists under random settings. Depends on kgs_pkg, the filter top and keypoint_verdict_checker.
module keypoint_grid_suppression_filter_top_tb;
  import kgs_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // pos_x, pos_y
  logic [IN_USER_W-1:0]  s_tuser;   // first_of_list
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // feature_id, cell_column, cell_row, pad
  logic [OUT_USER_W-1:0] m_tuser;   // accepted, verdict
  int                    error_count;
  int                    pending;
  bit                    send_steady;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  keypoint_grid_suppression_filter_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  keypoint_verdict_checker verdict_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .error_count(error_count), .pending(pending)
  );

  task automatic send_keypoint(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                               input logic first);
    int gap;
    if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    s_tuser <= first;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  // Drain every awaited verdict, then rewrite the whole register set.
  task automatic program_filter(input logic md, input logic [CINV_W-1:0] cinv,
                                input logic [PATCH_W-1:0] patch,
                                input logic [IMG_W-1:0] w, input logic [IMG_W-1:0] h,
                                input logic [MAXF_W-1:0] maxf, input logic [ID_W-1:0] idb);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    write_reg(REG_MIN_DIST, CFG_DATA_W'(md));
    write_reg(REG_CELL_INV, CFG_DATA_W'(cinv));
    write_reg(REG_PATCH_SIZE, CFG_DATA_W'(patch));
    write_reg(REG_IMG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMG_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_MAX_FEAT, CFG_DATA_W'(maxf));
    write_reg(REG_ID_BASE, CFG_DATA_W'(idb));
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_image_side();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 4096;
      2:       return $urandom_range(1, 4096);
      default: return $urandom_range(16, 320);
    endcase
  endfunction

  // Receiver: random stalls, with one long hold-off to back the block up.
  initial begin
    int gap;
    int taken;
    bit steady;
    bit held;
    m_tready = 1'b0;
    taken = 0;
    steady = 1'b0;
    held = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (taken == 150 && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      if ($urandom_range(0, 31) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    int rand_items;
    int w;
    int h;
    int len;
    logic md;
    logic [CINV_W-1:0] cinv;
    logic [PATCH_W-1:0] patch;
    logic [MAXF_W-1:0] maxf;
    logic [ID_W-1:0] idb;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MIN_DIST;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    send_steady = 1'b0;
    rand_items = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: grid check off, no border check, no quota
    send_keypoint(16'h0000, 16'h0000, 1'b1);
    send_keypoint(16'hFFFF, 16'hFFFF, 1'b0);

    // 8-pixel cells on a 64x48 image, quota of four, IDs wrapping past the top
    program_filter(1'b1, 8192, 8, 64, 48, 4, 32'hFFFF_FFFE);
    send_keypoint(32*16, 24*16, 1'b1);
    send_keypoint(33*16, 25*16, 1'b0);
    send_keypoint(40*16, 24*16, 1'b0);
    send_keypoint(2*16, 2*16, 1'b0);
    send_keypoint(4*16, 20*16, 1'b0);
    send_keypoint(5*16, 5*16, 1'b0);
    send_keypoint(40*16, 32*16, 1'b0);
    send_keypoint(60*16, 30*16, 1'b0);
    send_keypoint(59*16, 43*16, 1'b0);
    send_keypoint(16*16, 40*16, 1'b0);
    send_keypoint(0, 0, 1'b0);

    // change settings mid-list: grid size holds, quota lifts at once
    program_filter(1'b1, 17'h10000, 0, 4096, 4096, 0, 100);
    send_keypoint(16'hFFFF, 16'hFFFF, 1'b0);
    send_keypoint(100*16, 100*16, 1'b0);
    send_keypoint(16'hFFFF, 16'h0000, 1'b1);
    send_keypoint(4095*16, 1*16, 1'b0);

    // zero reciprocal and a one-pixel image
    program_filter(1'b1, 0, 1, 1, 1, 0, 0);
    send_keypoint(16, 16, 1'b1);
    program_filter(1'b1, 0, 0, 1, 1, 0, 0);
    send_keypoint(1234, 5678, 1'b1);
    send_keypoint(0, 0, 1'b0);

    // widest patch on the largest image
    program_filter(1'b0, 17'h10000, 255, 4096, 4096, 0, 0);
    send_keypoint(128*16, 128*16, 1'b1);
    send_keypoint(127*16, 4000*16, 1'b0);

    while (rand_items < 1300) begin
      md = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       cinv = '0;
        1:       cinv = 17'h10000;
        2:       cinv = CINV_W'($urandom_range(0, 65536));
        default: cinv = CINV_W'(65536 / $urandom_range(1, 16));
      endcase
      w = pick_image_side();
      h = pick_image_side();
      case ($urandom_range(0, 9))
        0, 1, 2: patch = '0;
        3:       patch = 8'hFF;
        default: patch = PATCH_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: maxf = '0;
        4:          maxf = 16'hFFFF;
        default:    maxf = MAXF_W'($urandom_range(1, 25));
      endcase
      case ($urandom_range(0, 3))
        0:       idb = '0;
        1:       idb = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        default: idb = $urandom;
      endcase
      program_filter(md, cinv, patch, IMG_W'(w), IMG_W'(h), maxf, idb);
      repeat ($urandom_range(1, 4)) begin
        len = $urandom_range(1, 50);
        for (int k = 0; k < len; k++) begin
          // mostly well-formed lists inside the image, some raw noise
          if ($urandom_range(0, 6) == 0)
            send_keypoint(POS_W'($urandom), POS_W'($urandom), 1'($urandom_range(0, 1)));
          else
            send_keypoint(POS_W'($urandom_range(0, w*16 - 1)),
                          POS_W'($urandom_range(0, h*16 - 1)), k == 0);
          rand_items++;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (32) @(negedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
